### hw/rtl/ipf_pkg.sv
`timescale 1ns / 1ps

package ipf_pkg;

  localparam int PACKET_BYTES = 64;
  localparam int CRC_POSITION = 60;
  localparam int AXIS_SLOTS   = 4;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;
  localparam logic [31:0] CRC_ONES = 32'hffffffff;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SEND = 1'b1;

  localparam logic CFG_MAGIC   = 1'b0;
  localparam logic CFG_VERSION = 1'b1;

  localparam logic [3:0] SLOT_FLAGS = 4'd0;
  localparam logic [3:0] SLOT_SEQ   = 4'd1;
  localparam logic [3:0] SLOT_TIME  = 4'd2;
  localparam logic [3:0] SLOT_GYRO  = 4'd3;
  localparam logic [3:0] SLOT_ACCEL = 4'd6;
  localparam logic [3:0] SLOT_BTN   = 4'd9;
  localparam logic [3:0] SLOT_AXIS  = 4'd10;
  localparam logic [3:0] SLOT_BATT  = 4'd14;
  localparam logic [3:0] SLOT_STAT  = 4'd15;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_MAGIC,
    SRC_VERSION,
    SRC_SIZE,
    SRC_STORE,
    SRC_CRC
  } src_sel_t;

  typedef struct packed {
    src_sel_t   src;
    logic [3:0] slot;
    logic [2:0] lane;
    logic       crc_en;
    logic       last;
  } ctrl_t;

  typedef struct packed {
    logic  busy;
    logic  issue;
    ctrl_t ctrl;
  } seq_ctl_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  function automatic logic [63:0] slot_mask(input logic [3:0] slot);
    logic [63:0] m;
    if (slot == SLOT_FLAGS) begin
      m = 64'h0000_0000_0000_00ff;
    end else if (slot == SLOT_TIME) begin
      m = 64'hffff_ffff_ffff_ffff;
    end else if (slot >= SLOT_AXIS) begin
      m = 64'h0000_0000_0000_ffff;
    end else begin
      m = 64'h0000_0000_ffff_ffff;
    end
    return m;
  endfunction

  // Microcode: one control word per packet byte.
  function automatic ctrl_t ucode(input logic [5:0] step);
    ctrl_t      c;
    logic [5:0] d;
    c.src    = SRC_ZERO;
    c.slot   = 4'd0;
    c.lane   = 3'd0;
    c.crc_en = 1'b1;
    c.last   = 1'b0;
    d        = 6'd0;
    if (step < 6'd4) begin
      c.src  = SRC_MAGIC;
      c.lane = step[2:0];
    end else if (step == 6'd4) begin
      c.src = SRC_VERSION;
    end else if (step == 6'd5) begin
      c.src  = SRC_STORE;
      c.slot = SLOT_FLAGS;
    end else if (step < 6'd8) begin
      d      = step - 6'd6;
      c.src  = SRC_SIZE;
      c.lane = d[2:0];
    end else if (step < 6'd12) begin
      d      = step - 6'd8;
      c.src  = SRC_STORE;
      c.slot = SLOT_SEQ;
      c.lane = d[2:0];
    end else if (step < 6'd20) begin
      d      = step - 6'd12;
      c.src  = SRC_STORE;
      c.slot = SLOT_TIME;
      c.lane = d[2:0];
    end else if (step < 6'd32) begin
      d      = step - 6'd20;
      c.src  = SRC_STORE;
      c.slot = SLOT_GYRO + {2'b00, d[3:2]};
      c.lane = {1'b0, d[1:0]};
    end else if (step < 6'd44) begin
      d      = step - 6'd32;
      c.src  = SRC_STORE;
      c.slot = SLOT_ACCEL + {2'b00, d[3:2]};
      c.lane = {1'b0, d[1:0]};
    end else if (step < 6'd48) begin
      d      = step - 6'd44;
      c.src  = SRC_STORE;
      c.slot = SLOT_BTN;
      c.lane = {1'b0, d[1:0]};
    end else if (step < 6'd56) begin
      d      = step - 6'd48;
      c.src  = (int'(d[2:1]) < AXIS_SLOTS) ? SRC_STORE : SRC_ZERO;
      c.slot = SLOT_AXIS + {2'b00, d[2:1]};
      c.lane = {2'b00, d[0]};
    end else if (step < 6'd58) begin
      d      = step - 6'd56;
      c.src  = SRC_STORE;
      c.slot = SLOT_BATT;
      c.lane = {2'b00, d[0]};
    end else if (step < 6'(CRC_POSITION)) begin
      d      = step - 6'd58;
      c.src  = SRC_STORE;
      c.slot = SLOT_STAT;
      c.lane = {2'b00, d[0]};
    end else begin
      d        = step - 6'(CRC_POSITION);
      c.src    = SRC_CRC;
      c.lane   = d[2:0];
      c.crc_en = 1'b0;
      c.last   = (step == 6'(PACKET_BYTES - 1));
    end
    return c;
  endfunction

endpackage

### hw/rtl/ipf_sample_store.sv
`timescale 1ns / 1ps

module ipf_sample_store (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [3:0]  wr_slot,
  input  logic [63:0] wr_data,
  input  logic [3:0]  rd_slot,
  input  logic [2:0]  rd_lane,
  output logic [7:0]  rd_byte
);

  logic [63:0] store_r [16];
  logic [63:0] entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        store_r[i] <= 64'd0;
      end
    end else if (wr_en) begin
      store_r[wr_slot] <= wr_data & ipf_pkg::slot_mask(wr_slot);
    end
  end

  always_comb begin
    entry   = store_r[rd_slot] >> {rd_lane, 3'b000};
    rd_byte = entry[7:0];
  end

endmodule

### hw/rtl/ipf_crc32.sv
`timescale 1ns / 1ps

module ipf_crc32 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clear,
  input  logic        en,
  input  logic [7:0]  data,
  output logic [31:0] crc
);

  logic [31:0] crc_r;
  logic [31:0] crc_nxt;

  always_comb begin
    crc_nxt = crc_r ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      crc_nxt = (crc_nxt >> 1) ^ (crc_nxt[0] ? ipf_pkg::CRC_POLY : 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= ipf_pkg::CRC_ONES;
    end else if (clear) begin
      crc_r <= ipf_pkg::CRC_ONES;
    end else if (en) begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r ^ ipf_pkg::CRC_ONES;

endmodule

### hw/rtl/ipf_sequencer.sv
`timescale 1ns / 1ps

module ipf_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              advance,
  output ipf_pkg::seq_ctl_t ctl
);

  ipf_pkg::seq_state_t state_r;
  ipf_pkg::seq_state_t state_nxt;
  logic [5:0]          step_r;
  logic [5:0]          step_nxt;
  ipf_pkg::ctrl_t      word;

  assign word = ipf_pkg::ucode(step_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ipf_pkg::SEQ_IDLE: begin
        if (start) begin
          state_nxt = ipf_pkg::SEQ_RUN;
        end
      end
      ipf_pkg::SEQ_RUN: begin
        if (advance && word.last) begin
          state_nxt = ipf_pkg::SEQ_IDLE;
        end
      end
      default: state_nxt = ipf_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    ctl.busy  = (state_r == ipf_pkg::SEQ_RUN);
    ctl.issue = (state_r == ipf_pkg::SEQ_RUN) && advance;
    ctl.ctrl  = word;
  end

  always_comb begin
    step_nxt = step_r;
    if (start) begin
      step_nxt = 6'd0;
    end else if (ctl.issue) begin
      step_nxt = word.last ? 6'd0 : step_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipf_pkg::SEQ_IDLE;
      step_r  <= 6'd0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

### hw/rtl/imu_packet_framer_crc32_core.sv
`timescale 1ns / 1ps

// Sample framer with CRC-32. An input word with opcode load writes one sample
// field into a sixteen-slot store, keeping only that field's low bits, and
// yields no output. An input word with opcode send makes the block emit one
// 64-byte packet, one byte per output word, with last_byte high on the final
// byte. The packet ends with a reflected CRC-32 over its first 60 bytes,
// computed as the bytes go out.
// A microcode step counter walks one control word per packet byte; once a send
// is accepted, the sequencer enters its run state and then issues the first
// byte into the output register. In_ready stays low while a packet is being
// emitted and rises as the last byte enters the output register.
// A stall on out_ready holds the current byte in the output register and
// freezes the step counter and CRC. Reset clears the store to zero, sets the
// magic word to zero and the version to one, and empties the output register.
// The configuration port writes the magic word at index 0 and the version
// at index 1 and is meant to be used while no packet is in flight.

module imu_packet_framer_crc32_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [3:0]  in_field_slot,
  input  logic [63:0] in_field_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_byte,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]       magic_r;
  logic [7:0]        version_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic              in_fire;
  logic              advance;
  ipf_pkg::seq_ctl_t seq;
  logic [7:0]        store_byte;
  logic [31:0]       crc;
  logic [31:0]       word32;
  logic [7:0]        byte_nxt;
  logic [15:0]       size_word;

  assign in_ready  = !seq.busy;
  assign in_fire   = in_valid && in_ready;
  assign advance   = !out_valid_r || out_ready;
  assign size_word = 16'(ipf_pkg::PACKET_BYTES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= 32'd0;
      version_r <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipf_pkg::CFG_MAGIC:   magic_r   <= cfg_wdata;
        ipf_pkg::CFG_VERSION: version_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  ipf_sequencer u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_fire && (in_opcode == ipf_pkg::OP_SEND)),
    .advance (advance),
    .ctl     (seq)
  );

  ipf_sample_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_fire && (in_opcode == ipf_pkg::OP_LOAD)),
    .wr_slot (in_field_slot),
    .wr_data (in_field_value),
    .rd_slot (seq.ctrl.slot),
    .rd_lane (seq.ctrl.lane),
    .rd_byte (store_byte)
  );

  always_comb begin
    word32   = 32'd0;
    byte_nxt = 8'd0;
    unique case (seq.ctrl.src)
      ipf_pkg::SRC_ZERO:    byte_nxt = 8'd0;
      ipf_pkg::SRC_MAGIC: begin
        word32   = magic_r >> {seq.ctrl.lane[1:0], 3'b000};
        byte_nxt = word32[7:0];
      end
      ipf_pkg::SRC_VERSION: byte_nxt = version_r;
      ipf_pkg::SRC_SIZE:    byte_nxt = seq.ctrl.lane[0] ? size_word[15:8] : size_word[7:0];
      ipf_pkg::SRC_STORE:   byte_nxt = store_byte;
      ipf_pkg::SRC_CRC: begin
        word32   = crc >> {seq.ctrl.lane[1:0], 3'b000};
        byte_nxt = word32[7:0];
      end
      default:              byte_nxt = 8'd0;
    endcase
  end

  ipf_crc32 u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (in_fire && (in_opcode == ipf_pkg::OP_SEND)),
    .en    (seq.issue && seq.ctrl.crc_en),
    .data  (byte_nxt),
    .crc   (crc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (seq.issue) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq.issue) begin
      out_byte_r <= byte_nxt;
      out_last_r <= seq.ctrl.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

  a_send_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_opcode == ipf_pkg::OP_SEND) |=> !in_ready)
    else $error("input still ready after a send was accepted");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(seq.issue && out_valid_r && !out_ready))
    else $error("output register overwritten while stalled");

  a_last_releases_input: assert property (@(posedge clk) disable iff (!rst_n)
    seq.issue && seq.ctrl.last |=> in_ready && out_valid && out_last_byte)
    else $error("last byte issue did not return the block to idle");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } pkt_byte_t;

  typedef struct {
    logic        op;
    logic [3:0]  slot;
    logic [63:0] value;
    bit          head_known;
    logic [63:0] head;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [3:0]  in_field_slot;
  logic [63:0] in_field_value;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_last_byte;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  logic [63:0] sample_mem [16];
  logic [31:0] magic_reg;
  logic [7:0]  version_reg;
  pkt_byte_t   expected_bytes [$];
  pkt_byte_t   oldest;
  stim_row_t   plan [$];

  int fail_count;
  int send_idle_pct;
  int recv_idle_pct;
  int phase;
  int stall_cycles;
  int hold_left;
  bit hold_done;

  imu_packet_framer_crc32_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_field_slot  (in_field_slot),
    .in_field_value (in_field_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_last_byte  (out_last_byte),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] trim_field(input logic [3:0] slot, input logic [63:0] value);
    logic [63:0] kept;
    if (slot == ipf_pkg::SLOT_FLAGS) begin
      kept = {56'd0, value[7:0]};
    end else if (slot == ipf_pkg::SLOT_TIME) begin
      kept = value;
    end else if (slot >= ipf_pkg::SLOT_AXIS) begin
      kept = {48'd0, value[15:0]};
    end else begin
      kept = {32'd0, value[31:0]};
    end
    return kept;
  endfunction

  function automatic void frame_packet();
    logic [7:0]  pkt [ipf_pkg::PACKET_BYTES];
    logic [31:0] crc;
    pkt_byte_t   e;
    foreach (pkt[i]) pkt[i] = 8'h00;
    for (int i = 0; i < 4; i++) pkt[i] = magic_reg[8*i +: 8];
    pkt[4] = version_reg;
    pkt[5] = sample_mem[ipf_pkg::SLOT_FLAGS][7:0];
    pkt[6] = 8'(ipf_pkg::PACKET_BYTES);
    pkt[7] = 8'(ipf_pkg::PACKET_BYTES >> 8);
    for (int i = 0; i < 4; i++) pkt[8 + i] = sample_mem[ipf_pkg::SLOT_SEQ][8*i +: 8];
    for (int i = 0; i < 8; i++) pkt[12 + i] = sample_mem[ipf_pkg::SLOT_TIME][8*i +: 8];
    for (int w = 0; w < 3; w++) begin
      for (int i = 0; i < 4; i++) begin
        pkt[20 + 4*w + i] = sample_mem[int'(ipf_pkg::SLOT_GYRO) + w][8*i +: 8];
        pkt[32 + 4*w + i] = sample_mem[int'(ipf_pkg::SLOT_ACCEL) + w][8*i +: 8];
      end
    end
    for (int i = 0; i < 4; i++) pkt[44 + i] = sample_mem[ipf_pkg::SLOT_BTN][8*i +: 8];
    for (int a = 0; a < ipf_pkg::AXIS_SLOTS && a < 4; a++) begin
      for (int i = 0; i < 2; i++) begin
        pkt[48 + 2*a + i] = sample_mem[int'(ipf_pkg::SLOT_AXIS) + a][8*i +: 8];
      end
    end
    for (int i = 0; i < 2; i++) begin
      pkt[56 + i] = sample_mem[ipf_pkg::SLOT_BATT][8*i +: 8];
      pkt[58 + i] = sample_mem[ipf_pkg::SLOT_STAT][8*i +: 8];
    end
    crc = ipf_pkg::CRC_ONES;
    for (int i = 0; i < ipf_pkg::CRC_POSITION; i++) begin
      crc = crc ^ {24'd0, pkt[i]};
      for (int b = 0; b < 8; b++) begin
        crc = crc[0] ? ((crc >> 1) ^ ipf_pkg::CRC_POLY) : (crc >> 1);
      end
    end
    crc = crc ^ ipf_pkg::CRC_ONES;
    for (int i = 0; i < 4; i++) pkt[ipf_pkg::CRC_POSITION + i] = crc[8*i +: 8];
    for (int i = 0; i < ipf_pkg::PACKET_BYTES; i++) begin
      e.data = pkt[i];
      e.last = (i == ipf_pkg::PACKET_BYTES - 1);
      expected_bytes.push_back(e);
    end
  endfunction

  function automatic stim_row_t make_row(input logic op, input logic [3:0] slot,
                                         input logic [63:0] value, input bit head_known,
                                         input logic [63:0] head);
    stim_row_t r;
    r.op = op;
    r.slot = slot;
    r.value = value;
    r.head_known = head_known;
    r.head = head;
    return r;
  endfunction

  task automatic offer_word(input logic op, input logic [3:0] slot, input logic [63:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_field_slot  <= slot;
    in_field_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == ipf_pkg::OP_LOAD) begin
      sample_mem[slot] = trim_field(slot, value);
    end else begin
      frame_packet();
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_format(input logic [31:0] magic, input logic [31:0] version_word);
    cfg_we    <= 1'b1;
    cfg_index <= ipf_pkg::CFG_MAGIC;
    cfg_wdata <= magic;
    @(posedge clk);
    cfg_index <= ipf_pkg::CFG_VERSION;
    cfg_wdata <= version_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    magic_reg   = magic;
    version_reg = version_word[7:0];
  endtask

  task automatic run_random(input int count);
    logic        op;
    logic [3:0]  slot;
    logic [63:0] value;
    int          pick;
    repeat (count) begin
      slot = 4'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 10) begin
        value = '1;
      end else if (pick < 20) begin
        value = '0;
      end else begin
        value = {$urandom, $urandom};
      end
      op = ($urandom_range(99) < 14) ? ipf_pkg::OP_SEND : ipf_pkg::OP_LOAD;
      offer_word(op, slot, value);
    end
  endtask

  always @(posedge clk) begin
    if (phase == 3 && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual byte %h last %b",
                 $time, out_byte, out_last_byte);
        fail_count++;
      end else begin
        oldest = expected_bytes.pop_front();
        if (oldest.data !== out_byte) begin
          $display("%0t: out_byte mismatch: expected %h, actual %h",
                   $time, oldest.data, out_byte);
          fail_count++;
        end
        if (oldest.last !== out_last_byte) begin
          $display("%0t: out_last_byte mismatch: expected %b, actual %b",
                   $time, oldest.last, out_last_byte);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    stim_row_t r;
    fail_count     = 0;
    stall_cycles   = 0;
    hold_left      = 0;
    hold_done      = 1'b0;
    phase          = 0;
    send_idle_pct  = 25;
    recv_idle_pct  = 51;
    magic_reg      = 32'd0;
    version_reg    = 8'd1;
    foreach (sample_mem[i]) sample_mem[i] = 64'd0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_opcode      <= ipf_pkg::OP_LOAD;
    in_field_slot  <= 4'd0;
    in_field_value <= 64'd0;
    out_ready      <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= ipf_pkg::CFG_MAGIC;
    cfg_wdata      <= 32'd0;

    // The first eight bytes of a packet are magic, version, flags and size.
    plan.push_back(make_row(ipf_pkg::OP_SEND, 4'hf, '1, 1'b1, 64'h0040_0001_0000_0000));
    for (int s = 0; s < 16; s++) begin
      plan.push_back(make_row(ipf_pkg::OP_LOAD, 4'(s), '1, 1'b0, 64'd0));
    end
    plan.push_back(make_row(ipf_pkg::OP_SEND, 4'h0, '0, 1'b1, 64'h0040_ff01_0000_0000));
    plan.push_back(make_row(ipf_pkg::OP_LOAD, ipf_pkg::SLOT_SEQ, 64'h0123_4567_89ab_cdef,
                            1'b0, 64'd0));
    plan.push_back(make_row(ipf_pkg::OP_LOAD, ipf_pkg::SLOT_FLAGS, 64'hffff_ffff_ffff_ff00,
                            1'b0, 64'd0));
    plan.push_back(make_row(ipf_pkg::OP_LOAD, ipf_pkg::SLOT_AXIS + 4'd3,
                            64'h0000_0000_0001_2345, 1'b0, 64'd0));
    plan.push_back(make_row(ipf_pkg::OP_LOAD, ipf_pkg::SLOT_TIME, 64'h8000_0000_0000_0001,
                            1'b0, 64'd0));
    plan.push_back(make_row(ipf_pkg::OP_SEND, 4'h5, 64'h5a5a_5a5a_5a5a_5a5a, 1'b1,
                            64'h0040_0001_0000_0000));
    plan.push_back(make_row(ipf_pkg::OP_LOAD, ipf_pkg::SLOT_GYRO, 64'h0000_0000_3f80_0000,
                            1'b0, 64'd0));
    plan.push_back(make_row(ipf_pkg::OP_SEND, 4'h9, 64'd0, 1'b0, 64'd0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    phase = 1;
    foreach (plan[k]) begin
      r = plan[k];
      offer_word(r.op, r.slot, r.value);
      if (r.head_known) begin
        for (int i = 0; i < 8; i++) begin
          expected_bytes[expected_bytes.size() - ipf_pkg::PACKET_BYTES + i].data =
            r.head[8*i +: 8];
        end
      end
    end
    wait_drained();

    set_format(32'hffff_ffff, 32'h0000_00ff);
    run_random(150);
    wait_drained();

    phase = 2;
    send_idle_pct = 51;
    recv_idle_pct = 25;
    set_format($urandom, {24'($urandom_range(16777215)), 8'h00});
    run_random(150);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_format(32'h0000_0000, $urandom);
    phase = 3;
    run_random(140);
    wait_drained();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
